// File: sv/bpsm_pkg.sv
// ----------------------------------------------------------------------------
// bpsm_pkg
// Shared types, constants and helpers for the battery power state monitor.
// ----------------------------------------------------------------------------
package bpsm_pkg;

    localparam int VOLT_W  = 16;
    localparam int CODE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int SUM_W   = 20;
    localparam int RECIP_W = 20;
    localparam int RECIP_SH = 23;

    // ceil(2^23 / 10), exact floor division for sums below 2^22
    localparam logic [RECIP_W-1:0] RECIP10 = 20'hCCCCD;

    localparam logic [VOLT_W-1:0] NORMAL_RST = 16'd3700;
    localparam logic [VOLT_W-1:0] LOW_RST    = 16'd3500;
    localparam logic [VOLT_W-1:0] STOP_RST   = 16'd3300;

    localparam logic [CIDX_W-1:0] REG_NORMAL = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LOW    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_STOP   = 2'd2;

    localparam logic [CODE_W-1:0] MODE_CODE_ON   = 2'd0;
    localparam logic [CODE_W-1:0] MODE_CODE_LOW  = 2'd1;
    localparam logic [CODE_W-1:0] MODE_CODE_STOP = 2'd2;

    typedef enum logic [2:0] {
        MODE_ON   = 3'b001,
        MODE_LOW  = 3'b010,
        MODE_STOP = 3'b100
    } mode_t;

    typedef enum logic [CODE_W-1:0] {
        ALARM_NONE   = 2'd0,
        ALARM_LOWPWR = 2'd1,
        ALARM_NOPWR  = 2'd2
    } alarm_t;

    typedef struct packed {
        logic [VOLT_W-1:0] normal;
        logic [VOLT_W-1:0] low;
        logic [VOLT_W-1:0] stop;
    } thr_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        unique case (m)
            MODE_ON:   c = MODE_CODE_ON;
            MODE_LOW:  c = MODE_CODE_LOW;
            MODE_STOP: c = MODE_CODE_STOP;
            default:   c = MODE_CODE_ON;
        endcase
        return c;
    endfunction

endpackage

// File: sv/bpsm_filter.sv
// ----------------------------------------------------------------------------
// bpsm_filter
// Smoothing step: next = (9*old + sample) / 10, or the sample when old is zero.
// ----------------------------------------------------------------------------
module bpsm_filter
    import bpsm_pkg::*;
(
    input  logic [VOLT_W-1:0] old_volt,
    input  logic [VOLT_W-1:0] sample,
    output logic [VOLT_W-1:0] new_volt
);

    logic [SUM_W-1:0]         sum;
    logic [SUM_W+RECIP_W-1:0] prod;

    always_comb begin
        sum  = SUM_W'({old_volt, 3'b000}) + SUM_W'(old_volt) + SUM_W'(sample);
        prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP10);
        if (old_volt == '0) begin
            new_volt = sample;
        end else begin
            new_volt = prod[RECIP_SH +: VOLT_W];
        end
    end

endmodule

// File: sv/bpsm_mode.sv
// ----------------------------------------------------------------------------
// bpsm_mode
// Power mode transition and alarm generation from the smoothed voltage.
// ----------------------------------------------------------------------------
module bpsm_mode
    import bpsm_pkg::*;
(
    input  mode_t             mode_cur,
    input  logic [VOLT_W-1:0] volt,
    input  thr_t              thr,
    output mode_t             mode_new,
    output alarm_t            alarm
);

    always_comb begin
        mode_new = mode_cur;
        alarm    = ALARM_NONE;
        unique case (mode_cur)
            MODE_STOP: begin
                if (volt >= thr.normal) begin
                    mode_new = MODE_ON;
                end
            end
            MODE_LOW: begin
                if (volt >= thr.normal) begin
                    mode_new = MODE_ON;
                end else if (volt <= thr.stop) begin
                    mode_new = MODE_STOP;
                    alarm    = ALARM_NOPWR;
                end
            end
            MODE_ON: begin
                if (volt <= thr.stop) begin
                    mode_new = MODE_STOP;
                end else if (volt <= thr.low) begin
                    mode_new = MODE_LOW;
                    alarm    = ALARM_LOWPWR;
                end
            end
            default: begin
                mode_new = mode_cur;
            end
        endcase
    end

endmodule

// File: sv/battery_power_state_monitor.sv
// An accepted sample passes through the input register and then the result register.
// Throughput: one sample per cycle while m_ready holds; the filter and mode update are combinational.
// The result register decouples the sides, so a new sample is taken while one waits.
// Reset (aresetn low, synchronous): smoothed voltage zero, mode on, thresholds
// 3700/3500/3300, both pipeline registers empty.
// ----------------------------------------------------------------------------
// battery_power_state_monitor
// Input register, combinational filter and mode update, result register.
// ----------------------------------------------------------------------------
module battery_power_state_monitor
    import bpsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [VOLT_W-1:0] cfg_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [VOLT_W-1:0] s_voltage_sample,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [VOLT_W-1:0] m_smoothed_voltage,
    output logic [CODE_W-1:0] m_power_mode,
    output logic [CODE_W-1:0] m_alarm_code
);

    thr_t              thr_reg;
    logic              in_valid_reg;
    logic [VOLT_W-1:0] in_sample_reg;
    logic              out_valid_reg;
    logic [VOLT_W-1:0] out_volt_reg;
    logic [CODE_W-1:0] out_mode_reg;
    alarm_t            out_alarm_reg;
    logic [VOLT_W-1:0] filt_reg;
    logic [VOLT_W-1:0] filt_next;
    mode_t             mode_reg;
    mode_t             mode_next;
    alarm_t            alarm_next;
    logic              out_adv;
    logic              proc;

    assign out_adv   = !out_valid_reg || m_ready;
    assign proc      = in_valid_reg && out_adv;
    assign s_ready   = !in_valid_reg || out_adv;
    assign cfg_ready = 1'b1;

    assign m_valid            = out_valid_reg;
    assign m_smoothed_voltage = out_volt_reg;
    assign m_power_mode       = out_mode_reg;
    assign m_alarm_code       = out_alarm_reg;

    bpsm_filter u_filter (
        .old_volt (filt_reg),
        .sample   (in_sample_reg),
        .new_volt (filt_next)
    );

    bpsm_mode u_mode (
        .mode_cur (mode_reg),
        .volt     (filt_next),
        .thr      (thr_reg),
        .mode_new (mode_next),
        .alarm    (alarm_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.normal <= NORMAL_RST;
            thr_reg.low    <= LOW_RST;
            thr_reg.stop   <= STOP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NORMAL: thr_reg.normal <= cfg_data;
                REG_LOW:    thr_reg.low    <= cfg_data;
                REG_STOP:   thr_reg.stop   <= cfg_data;
                default:    thr_reg        <= thr_reg;
            endcase
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            mode_reg      <= MODE_ON;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc) begin
                filt_reg <= filt_next;
                mode_reg <= mode_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_voltage_sample;
        end
        if (proc) begin
            out_volt_reg  <= filt_next;
            out_mode_reg  <= mode_code(mode_next);
            out_alarm_reg <= alarm_next;
        end
    end

`ifndef SYNTHESIS
    a_lowpwr_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alarm_code == ALARM_LOWPWR) |-> (m_power_mode == MODE_CODE_LOW))
        else $error("low-power alarm without low mode");

    a_nopwr_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alarm_code == ALARM_NOPWR) |-> (m_power_mode == MODE_CODE_STOP))
        else $error("no-power alarm without stop mode");

    a_proc_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> (m_valid && m_smoothed_voltage == filt_reg))
        else $error("processed transaction did not reach the result register");

    a_stop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && mode_reg == MODE_STOP && filt_next < thr_reg.normal)
        |=> (mode_reg == MODE_STOP))
        else $error("stop mode left below normal threshold");
`endif

endmodule
